/* rtl/timed_event_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// Timed event sequencer assertion macros
// Shared property shapes, clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_SEQUENCER_DEFINES_SVH
`define TIMED_EVENT_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define TES_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timed_event_sequencer: implication check failed");

// next-cycle implication
`define TES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timed_event_sequencer: next-cycle check failed");

`endif

/* rtl/tes_pkg.sv */
// ----------------------------------------------------------------------------
// Timed event sequencer package
// Field widths, request and register codes, defaults and the state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tes_pkg;

    localparam int FUNC_W     = 2;
    localparam int TIME_IN_W  = 32;
    localparam int SLOT_W     = 8;
    localparam int FIRED_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int MAX_EVENTS_DEF = 256;
    localparam int MAX_FIRES_DEF  = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REWIND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMING_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FLUSH
    } t_state;

endpackage

/* rtl/tes_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying tick, table write and rewind requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tes_req_if
    import tes_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [TIME_IN_W-1:0] time_now;
    logic [SLOT_W-1:0]    slot;
    logic [TIME_IN_W-1:0] start_time;

    modport source (output valid, output func, output time_now, output slot,
                    output start_time, input ready);
    modport sink   (input valid, input func, input time_now, input slot,
                    input start_time, output ready);
endinterface

/* rtl/tes_fire_if.sv */
// ----------------------------------------------------------------------------
// Fire channel
// Valid/ready channel carrying one fired event index per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tes_fire_if
    import tes_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FIRED_W-1:0] fired_index;
    logic               last;

    modport source (output valid, output fired_index, output last, input ready);
    modport sink   (input valid, input fired_index, input last, output ready);
endinterface

/* rtl/tes_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/timed_event_sequencer.sv */
// ----------------------------------------------------------------------------
// Timed event sequencer
// Steps through a table of event start times held in RAM, firing events
// against the time carried by tick requests.
// ----------------------------------------------------------------------------
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        func, time_now, slot, start_time
//   o_fire    out  valid/ready        fired_index, last
//   i_cfg_*   in   write enable only  index, data
//
// A table write or rewind completes in idle. A tick fires up to MAX_FIRES
// events, with one RAM read per checked event; a tick that finds nothing to
// check leaves the sequencer idle. Output stalls hold the check loop.
// Reset clears the index, last fire time and registers; the table is not
// cleared. One request is in work at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timed_event_sequencer_defines.svh"

module timed_event_sequencer
    import tes_pkg::*;
#(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF,
    parameter int MAX_FIRES  = MAX_FIRES_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tes_req_if.sink               i_req,
    tes_fire_if.source            o_fire,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int IW = $clog2(MAX_EVENTS + 1);
    localparam int FW = $clog2(MAX_FIRES + 1);

    t_state r_state, n_state;

    logic               r_loop_enable;
    logic               r_timing_mode;
    logic [COUNT_W-1:0] r_event_count;

    logic [IW-1:0]        r_idx;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_last_fire;
    logic [FW-1:0]        r_fires;
    logic                 r_pend_v;
    logic [IW-1:0]        r_pend_idx;
    logic                 r_out_v;
    logic [FIRED_W-1:0]   r_out_idx;
    logic                 r_out_last;

    logic [IW-1:0]        count_eff;
    logic [IW-1:0]        start_idx;
    logic [IW-1:0]        idx_inc;
    logic [IW-1:0]        idx_next;
    logic [TIME_BITS-1:0] rd_data;
    logic [TIME_BITS-1:0] elapsed;
    logic                 accept;
    logic                 tick_go;
    logic                 out_free;
    logic                 hold;
    logic                 hit;
    logic                 at_end;
    logic                 stop;
    logic                 wr_en;

    logic          in_ready;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          fire;
    logic          out_load;
    logic          out_last;

    // ---------------------------------------------------------------- datapath
    assign count_eff = (32'(r_event_count) > MAX_EVENTS) ? IW'(MAX_EVENTS)
                                                          : IW'(r_event_count);
    assign start_idx = (r_idx >= count_eff) ? '0 : r_idx;
    assign idx_inc   = r_idx + IW'(1);
    assign at_end    = (idx_inc >= count_eff);
    assign idx_next  = (r_loop_enable && at_end) ? '0 : idx_inc;
    assign stop      = ((r_fires + FW'(1)) == FW'(MAX_FIRES)) || (!r_loop_enable && at_end);

    assign accept  = i_req.valid && in_ready;
    assign tick_go = accept && (i_req.func == FUNC_TICK) && (count_eff != '0) &&
                     ((r_idx < count_eff) || r_loop_enable);
    assign wr_en   = accept && (i_req.func == FUNC_WRITE) && (32'(i_req.slot) < MAX_EVENTS);

    assign elapsed  = r_now - r_last_fire;
    assign hit      = r_timing_mode ? (elapsed >= rd_data) : (r_now >= rd_data);
    assign out_free = !r_out_v || o_fire.ready;
    assign hold     = r_pend_v && !out_free;

    tes_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_EVENTS)
    ) u_times (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_req.slot)),
        .i_wdata (TIME_BITS'(i_req.start_time)),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // ------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (tick_go) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!hold) begin
                    if (!hit) begin
                        n_state = ST_IDLE;
                    end else if (stop) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // --------------------------------------------------------------- outputs
    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = AW'(start_idx);
        fire     = 1'b0;
        out_load = 1'b0;
        out_last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                rd_en    = tick_go;
            end
            ST_CHECK: begin
                if (!hold) begin
                    if (hit) begin
                        fire     = 1'b1;
                        out_load = r_pend_v;
                        rd_en    = !stop;
                        rd_addr  = AW'(idx_next);
                    end else begin
                        out_load = r_pend_v;
                        out_last = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                out_load = out_free;
                out_last = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_loop_enable <= 1'b0;
            r_timing_mode <= 1'b0;
            r_event_count <= '0;
            r_idx         <= '0;
            r_last_fire   <= '0;
            r_fires       <= '0;
            r_pend_v      <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOOP_ENABLE: r_loop_enable <= i_cfg_data[0];
                    CFG_TIMING_MODE: r_timing_mode <= i_cfg_data[0];
                    CFG_EVENT_COUNT: r_event_count <= i_cfg_data;
                    default: ;
                endcase
            end

            if (accept && (i_req.func == FUNC_REWIND)) begin
                r_idx <= '0;
            end else if (tick_go) begin
                r_idx <= start_idx;
            end else if (fire) begin
                r_idx <= idx_next;
            end

            if (tick_go) begin
                r_fires <= '0;
            end else if (fire) begin
                r_fires <= r_fires + FW'(1);
            end

            if (fire) begin
                r_last_fire <= r_now;
                r_pend_v    <= 1'b1;
            end else if (out_load) begin
                r_pend_v <= 1'b0;
            end

            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_fire.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_now <= TIME_BITS'(i_req.time_now);
        end
        if (fire) begin
            r_pend_idx <= r_idx;
        end
        if (out_load) begin
            r_out_idx  <= FIRED_W'(r_pend_idx);
            r_out_last <= out_last;
        end
    end

    assign i_req.ready        = in_ready;
    assign o_fire.valid       = r_out_v;
    assign o_fire.fired_index = r_out_idx;
    assign o_fire.last        = r_out_last;

    // ------------------------------------------------------------ assertions
    `TES_ASSERT_IMPLY(a_idle_no_pend, (r_state == ST_IDLE), !r_pend_v)
    `TES_ASSERT_IMPLY(a_flush_pend, (r_state == ST_FLUSH), r_pend_v)
    `TES_ASSERT_IMPLY(a_check_idx, (r_state == ST_CHECK), (r_idx < count_eff))
    `TES_ASSERT_IMPLY(a_fire_cap, (r_state == ST_CHECK), (32'(r_fires) < MAX_FIRES))
    `TES_ASSERT_NEXT(a_miss_idle, (r_state == ST_CHECK) && !hold && !hit, (r_state == ST_IDLE))

endmodule
